>>> design/pcm_linear_upsample_packer_defines.svh
// Assertion macros shared by the upsampler checker.
`ifndef PCM_LINEAR_UPSAMPLE_PACKER_DEFINES_SVH
`define PCM_LINEAR_UPSAMPLE_PACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PCMUP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcmup check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PCMUP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcmup check failed");

`endif

>>> design/pcmup_pkg.sv
// Types and constants shared by the PCM upsampler modules.
`default_nettype none
package pcmup_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int WORD_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int RATIO_W    = 3;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd1;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 3'd1;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd14418;

  // Rounding and saturation of the gain product
  localparam logic [32:0]         ROUND_HALF   = 33'd32768;
  localparam logic [16:0]         SAT_MAG_NEG  = 17'd32768;
  localparam logic [16:0]         SAT_MAG_POS  = 17'd32767;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN   = 16'h8000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 16'h7FFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_GAIN
  } pcmup_state_t;

  typedef struct packed {
    logic store;  // keep low byte
    logic load;   // form sample, set up interpolation
    logic div;    // reciprocal multiply
    logic fix;    // quotient correction
    logic emit;   // gain, saturate, load output register
  } pcmup_cmd_t;

  typedef struct packed {
    logic byte_held;
    logic last;
    logic out_free;
  } pcmup_stat_t;

endpackage
`default_nettype wire

>>> design/pcmup_regs.sv
// Configuration registers: ratio and gain.
`default_nettype none
module pcmup_regs #(
  parameter int MAX_RATIO = 4,
  localparam int RW = $clog2(MAX_RATIO + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcmup_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcmup_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [RW-1:0]                       ratio,
  output logic [pcmup_pkg::GAIN_W-1:0]        gain
);
  import pcmup_pkg::*;

  logic [RATIO_W-1:0] ratio_reg;
  logic               ratio_ok;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_reg <= RATIO_RESET;
      gain      <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RATIO: ratio_reg <= cfg_data[RATIO_W-1:0];
        CFG_GAIN:  gain      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero or above the maximum runs as ratio 1
  assign ratio_ok = (ratio_reg != '0) && (int'(ratio_reg) <= MAX_RATIO);
  assign ratio    = ratio_ok ? RW'(ratio_reg) : RW'(1);

endmodule
`default_nettype wire

>>> design/pcmup_ctrl.sv
// Sequencer for the upsampler: accept, divide, correct, emit.
`default_nettype none
module pcmup_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  pcmup_pkg::pcmup_stat_t  stat,
  output pcmup_pkg::pcmup_cmd_t   cmd
);
  import pcmup_pkg::*;

  pcmup_state_t state, state_next;
  logic         accept;

  assign accept = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && stat.byte_held) state_next = ST_DIV;
      end
      ST_DIV:  state_next = ST_FIX;
      ST_FIX:  state_next = ST_GAIN;
      ST_GAIN: begin
        if (stat.out_free) state_next = stat.last ? ST_IDLE : ST_DIV;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.store = accept && !stat.byte_held;
        cmd.load  = accept && stat.byte_held;
      end
      ST_DIV:  cmd.div  = 1'b1;
      ST_FIX:  cmd.fix  = 1'b1;
      ST_GAIN: cmd.emit = stat.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> design/pcmup_dp.sv
// Datapath: byte pairing, interpolation, divide by ratio, gain, output register.
`default_nettype none
module pcmup_dp #(
  parameter int MAX_RATIO = 4,
  localparam int RW = $clog2(MAX_RATIO + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pcmup_pkg::pcmup_cmd_t               cmd,
  output pcmup_pkg::pcmup_stat_t              stat,
  input  logic [pcmup_pkg::BYTE_W-1:0]        data_byte,
  input  logic [RW-1:0]                       ratio,
  input  logic [pcmup_pkg::GAIN_W-1:0]        gain,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [pcmup_pkg::WORD_W-1:0]        out_word,
  output logic                                last_in_run
);
  import pcmup_pkg::*;

  localparam int NW        = SAMPLE_W + RW;  // signed interpolation numerator
  localparam int MW        = NW - 1;         // its magnitude
  localparam int DIV_SHIFT = MW;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int QR_W      = MW + RW;

  // floor(2^DIV_SHIFT / r); entry 0 unused
  logic [RECIP_W-1:0] recip_tab [MAX_RATIO+1];
  assign recip_tab[0] = '0;
  for (genvar g = 1; g <= MAX_RATIO; g++) begin : g_recip
    localparam int unsigned RECIP = (1 << DIV_SHIFT) / g;
    assign recip_tab[g] = RECIP_W'(RECIP);
  end

  logic [BYTE_W-1:0]          held_byte;
  logic                       byte_held;
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic                       seen_first;
  logic signed [NW-1:0]       acc;
  logic signed [SAMPLE_W:0]   delta;
  logic [RW-1:0]              k;
  logic [MW-1:0]              num_mag;
  logic                       num_neg;
  logic [MW-1:0]              q0;
  logic [SAMPLE_W-1:0]        frame_mag;
  logic                       frame_neg;

  // load
  logic signed [SAMPLE_W-1:0]  cur;
  logic signed [SAMPLE_W-1:0]  base;
  logic signed [RW:0]          ratio_s;
  logic signed [SAMPLE_W+RW:0] base_x_ratio;

  assign cur          = $signed({data_byte, held_byte});
  assign base         = seen_first ? prev_sample : cur;  // first sample repeats
  assign ratio_s      = $signed({1'b0, ratio});
  assign base_x_ratio = base * ratio_s;

  // divide
  logic [NW-1:0]           acc_abs;
  logic [MW+RECIP_W-1:0]   recip_prod;

  assign acc_abs    = acc[NW-1] ? (NW'(0) - acc) : acc;
  assign recip_prod = acc_abs[MW-1:0] * recip_tab[ratio];

  // correct: reciprocal quotient is exact or one low
  logic [QR_W-1:0] q0r;
  logic [MW-1:0]   rem;
  logic [MW-1:0]   q_adj;

  assign q0r   = q0 * ratio;
  assign rem   = num_mag - q0r[MW-1:0];
  assign q_adj = (rem >= MW'(ratio)) ? q0 + MW'(1) : q0;

  // gain, round half away from zero, saturate
  logic [31:0]         gprod;
  logic [32:0]         grnd;
  logic [16:0]         gmag;
  logic [16:0]         gneg;
  logic [SAMPLE_W-1:0] scaled;

  assign gprod = frame_mag * gain;
  assign grnd  = {1'b0, gprod} + ROUND_HALF;
  assign gmag  = grnd[32:16];
  assign gneg  = 17'd0 - gmag;

  always_comb begin
    if (frame_neg) begin
      scaled = (gmag > SAT_MAG_NEG) ? SAMPLE_MIN : gneg[SAMPLE_W-1:0];
    end else begin
      scaled = (gmag > SAT_MAG_POS) ? SAMPLE_MAX : gmag[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_held  <= 1'b0;
      seen_first <= 1'b0;
    end else if (cmd.store) begin
      byte_held <= 1'b1;
    end else if (cmd.load) begin
      byte_held  <= 1'b0;
      seen_first <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      held_byte <= data_byte;
    end
    if (cmd.load) begin
      prev_sample <= cur;
      acc         <= base_x_ratio[NW-1:0];
      delta       <= {cur[SAMPLE_W-1], cur} - {base[SAMPLE_W-1], base};
      k           <= '0;
    end else if (cmd.emit) begin
      acc <= acc + NW'(delta);
      k   <= k + RW'(1);
    end
    if (cmd.div) begin
      num_mag <= acc_abs[MW-1:0];
      num_neg <= acc[NW-1];
      q0      <= recip_prod[DIV_SHIFT +: MW];
    end
    if (cmd.fix) begin
      frame_mag <= q_adj[SAMPLE_W-1:0];
      frame_neg <= num_neg;
    end
    if (cmd.emit) begin
      out_word    <= {scaled, {(WORD_W-SAMPLE_W){1'b0}}};
      last_in_run <= stat.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.byte_held = byte_held;
  assign stat.last      = (k == ratio - RW'(1));
  assign stat.out_free  = !out_valid || !out_stall;

endmodule
`default_nettype wire

>>> design/pcm_linear_upsample_packer.sv
// A pairing byte starts its run of frames on accept; no new byte is taken until the run's last frame is emitted.
// An odd byte is only stored; an even byte forms a sample and yields ratio frames, each held while the output stalls.
// Each frame passes through the reciprocal multiply, quotient fix and gain multiply steps in turn.
// Reset (rst, synchronous, active high): ratio 1, gain 14418, no byte held,
// no sample seen, output empty.
`default_nettype none
module pcm_linear_upsample_packer #(
  parameter int MAX_RATIO = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  // byte request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pcmup_pkg::BYTE_W-1:0]      data_byte,
  // frame request channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pcmup_pkg::WORD_W-1:0] left_word,
  output logic signed [pcmup_pkg::WORD_W-1:0] right_word,
  output logic                              last_in_run,
  // register write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcmup_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcmup_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pcmup_pkg::*;

  localparam int RW = $clog2(MAX_RATIO + 1);

  logic [RW-1:0]     ratio;    // effective ratio, 1..MAX_RATIO
  logic [GAIN_W-1:0] gain;
  pcmup_cmd_t        cmd;
  pcmup_stat_t       stat;
  logic [WORD_W-1:0] out_word;

  pcmup_regs #(.MAX_RATIO(MAX_RATIO)) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ratio     (ratio),
    .gain      (gain)
  );

  // Sequencer: one sample's frames at a time; idle state takes bytes.
  pcmup_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Interpolation steps by adding (cur - prev) to prev*ratio each frame;
  // the divide by ratio is a reciprocal multiply plus a one-step fixup.
  // The output register lets the next byte in while the last frame waits.
  pcmup_dp #(.MAX_RATIO(MAX_RATIO)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .data_byte   (data_byte),
    .ratio       (ratio),
    .gain        (gain),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_word    (out_word),
    .last_in_run (last_in_run)
  );

  // same slot on both stereo channels
  assign left_word  = $signed(out_word);
  assign right_word = $signed(out_word);

endmodule
`default_nettype wire

>>> design/pcmup_checker.sv
// Port-level checks for the upsampler, bound to the top level.
`default_nettype none
`include "pcm_linear_upsample_packer_defines.svh"
module pcmup_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [pcmup_pkg::WORD_W-1:0]  left_word,
  input logic signed [pcmup_pkg::WORD_W-1:0]  right_word,
  input logic                                 last_in_run
);

  `PCMUP_ASSERT_IMP(a_same_slot, out_valid, left_word == right_word)
  `PCMUP_ASSERT_IMP(a_low_half_zero, out_valid, left_word[15:0] == 16'h0000)
  // mid-run the sequencer is busy with the next frame
  `PCMUP_ASSERT_IMP(a_busy_mid_run, out_valid && !last_in_run, in_stall)
  `PCMUP_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(left_word) && $stable(last_in_run))

endmodule

bind pcm_linear_upsample_packer pcmup_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .left_word   (left_word),
  .right_word  (right_word),
  .last_in_run (last_in_run)
);
`default_nettype wire
